### rtl/wbs_pkg.sv
// shared constants and types for the word break segmenter
`timescale 1ns / 1ps
`default_nettype none

package wbs_pkg;

    localparam int MAX_WORDS_DEF    = 16;
    localparam int MAX_WORD_LEN_DEF = 16;

    localparam int SYM_W = 8;
    localparam int CMD_W = 2;

    localparam logic [CMD_W-1:0] CMD_DICT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // control from the sequencer to every history cell
    typedef struct packed {
        logic shift;
        logic restart;
    } cell_ctrl_t;

    // running compare result handed from cell to cell
    typedef struct packed {
        logic ok;
        logic start;
    } chain_t;

endpackage

`default_nettype wire

### rtl/word_break_segmenter.sv
// word break segmenter top level: dictionary loader, word scan sequencer, cell row
//
// Input channel s_*: one request per cycle at most. tuser carries the command
// (dictionary byte, text byte, clear), tdata the byte, tlast ends a word or a text.
// Dictionary bytes, clears and unknown commands leave the input ready and give no result.
// A text byte gives one result on m_*: tdata bit 0 says whether the text so far
// splits into dictionary words, tlast marks the final text byte, tuser bit 0 is
// the sticky dropped-word flag.
// A text byte shifts into the cell row, then the stored words are read from the
// word ram one per cycle and compared against the row in parallel. The block
// takes no new request until the scan is done and its result is in the output
// register. The single ram read port is why the words are read one at a time.
// The result sits in an output register; while it waits for m_tready the block
// still takes dictionary and clear requests and the next text byte, and a
// finished scan holds until the register frees.
// Reset empties the dictionary, clears the flag and restarts the text.
`timescale 1ns / 1ps
`default_nettype none

module word_break_segmenter #(
    parameter int MAX_WORDS    = wbs_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // symbol
    input  wire logic [1:0] s_tuser,   // cmd
    input  wire logic       s_tlast,   // last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // prefix_breakable, then zero fill
    output logic      [0:0] m_tuser,   // dict_overflow
    output logic            m_tlast    // text_end
);

    import wbs_pkg::*;

    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int ROW_W  = MAX_WORD_LEN * SYM_W;
    localparam int RAM_W  = ROW_W + LEN_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] word_count_reg, word_count_next;
    logic [LEN_W-1:0] load_pos_reg, load_pos_next;
    logic             too_long_reg, too_long_next;
    logic             overflow_reg, overflow_next;
    logic [ROW_W-1:0] load_row_reg, load_row_next;
    logic             split0_reg, split0_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic             acc_reg, acc_next;
    logic             fin_reg, fin_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_break_reg, out_break_next;
    logic             out_end_reg, out_end_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             accept;
    logic             is_dict, is_text, is_clear;
    logic             room;
    logic             pos_fits;
    logic             word_bad;
    logic             ram_wr;
    logic [RAM_W-1:0] ram_wdata;
    logic             issuing;
    logic             done;
    logic             finish;
    logic [RAM_W-1:0] ram_rdata;
    logic             match;
    cell_ctrl_t       cell_ctrl;

    logic [SYM_W-1:0] hist_byte [MAX_WORD_LEN+1];
    logic             hist_bit  [MAX_WORD_LEN+1];
    chain_t           chain     [MAX_WORD_LEN+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign is_dict  = accept & (s_tuser == CMD_DICT);
    assign is_text  = accept & (s_tuser == CMD_TEXT);
    assign is_clear = accept & (s_tuser == CMD_CLEAR);

    assign room     = (word_count_reg < CNT_W'(MAX_WORDS));
    assign pos_fits = (load_pos_reg < LEN_W'(MAX_WORD_LEN));
    assign word_bad = too_long_reg | ~pos_fits | ~room;
    assign ram_wr   = is_dict & s_tlast & ~word_bad;
    assign ram_wdata = {load_pos_reg + LEN_W'(1), load_row_next};

    assign issuing = (state_reg == ST_SCAN) & (issue_reg < word_count_reg);
    assign done    = (state_reg == ST_SCAN) & ~issuing & ~pend_reg;
    assign finish  = done & (~out_valid_reg | m_tready);

    // dictionary loader and clear
    always_comb
    begin
        word_count_next = word_count_reg;
        load_pos_next   = load_pos_reg;
        too_long_next   = too_long_reg;
        overflow_next   = overflow_reg;
        load_row_next   = load_row_reg;
        if (is_dict)
        begin
            if (pos_fits)
            begin
                // newest byte at the bottom, so row byte j lines up with text byte j
                load_row_next = (load_row_reg << SYM_W) | ROW_W'(s_tdata);
                load_pos_next = load_pos_reg + LEN_W'(1);
            end
            else
            begin
                too_long_next = 1'b1;
            end
            if (s_tlast)
            begin
                if (word_bad)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    word_count_next = word_count_reg + CNT_W'(1);
                end
                load_pos_next = '0;
                too_long_next = 1'b0;
            end
        end
        else if (is_clear)
        begin
            word_count_next = '0;
            load_pos_next   = '0;
            too_long_next   = 1'b0;
            overflow_next   = 1'b0;
        end
    end

    // scan sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        pend_next      = issuing;
        acc_next       = acc_reg | (pend_reg & match);
        fin_next       = fin_reg;
        split0_next    = split0_reg;
        out_valid_next = out_valid_reg;
        out_break_next = out_break_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_text)
                begin
                    state_next = ST_SCAN;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    acc_next   = 1'b0;
                    fin_next   = s_tlast;
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_break_next = acc_reg;
                    out_end_next   = fin_reg;
                    out_ovf_next   = overflow_reg;
                    split0_next    = fin_reg ? 1'b1 : acc_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            word_count_reg <= '0;
            load_pos_reg   <= '0;
            too_long_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            split0_reg     <= 1'b1;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            acc_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            load_pos_reg   <= load_pos_next;
            too_long_reg   <= too_long_next;
            overflow_reg   <= overflow_next;
            split0_reg     <= split0_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            acc_reg        <= acc_next;
            fin_reg        <= fin_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        load_row_reg  <= load_row_next;
        out_break_reg <= out_break_next;
        out_end_reg   <= out_end_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // one row per word: length above the bytes
    wbs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WORDS)
    ) u_words (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (word_count_reg[ADDR_W-1:0]),
        .wr_data (ram_wdata),
        .rd_en   (issuing),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign cell_ctrl.shift   = is_text;
    assign cell_ctrl.restart = finish & fin_reg;

    assign hist_byte[0]   = s_tdata;
    assign hist_bit[0]    = split0_reg;
    assign chain[0].ok    = 1'b1;
    assign chain[0].start = 1'b0;

    for (genvar j = 0; j < MAX_WORD_LEN; j++)
    begin : g_cell
        wbs_cell #(
            .POS   (j),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .byte_in   (hist_byte[j]),
            .bit_in    (hist_bit[j]),
            .byte_out  (hist_byte[j+1]),
            .bit_out   (hist_bit[j+1]),
            .word_byte (ram_rdata[j*SYM_W +: SYM_W]),
            .word_len  (ram_rdata[ROW_W +: LEN_W]),
            .chain_in  (chain[j]),
            .chain_out (chain[j+1])
        );
    end

    assign match = chain[MAX_WORD_LEN].ok & chain[MAX_WORD_LEN].start;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_break_reg};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_end_reg;

endmodule

`default_nettype wire

### rtl/wbs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module wbs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/wbs_cell.sv
// one history cell: a text byte, a prefix bit and its slice of the word compare
`timescale 1ns / 1ps
`default_nettype none

module wbs_cell #(
    parameter int POS   = 0,
    parameter int LEN_W = 5
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire wbs_pkg::cell_ctrl_t       ctrl,
    input  wire logic [wbs_pkg::SYM_W-1:0] byte_in,
    input  wire logic                      bit_in,
    output logic      [wbs_pkg::SYM_W-1:0] byte_out,
    output logic                           bit_out,
    input  wire logic [wbs_pkg::SYM_W-1:0] word_byte,
    input  wire logic [LEN_W-1:0]          word_len,
    input  wire wbs_pkg::chain_t           chain_in,
    output wbs_pkg::chain_t                chain_out
);

    import wbs_pkg::*;

    logic [SYM_W-1:0] byte_reg;
    logic             bit_reg;
    logic             beyond;
    logic             at_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
            bit_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                byte_reg <= byte_in;
            end
            if (ctrl.restart)
            begin
                bit_reg <= 1'b0;
            end
            else if (ctrl.shift)
            begin
                bit_reg <= bit_in;
            end
        end
    end

    // positions past the word length do not take part
    assign beyond = (LEN_W'(POS) >= word_len);
    // prefix bit held here sits just before a word of length pos+1
    assign at_len = (LEN_W'(POS + 1) == word_len);

    assign chain_out.ok    = chain_in.ok & (beyond | (byte_reg == word_byte));
    assign chain_out.start = chain_in.start | (at_len & bit_reg);

    assign byte_out = byte_reg;
    assign bit_out  = bit_reg;

endmodule

`default_nettype wire

### rtl/wbs_checker.sv
// port-level checks for the word break segmenter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module wbs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [1:0] s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [0:0] m_tuser,
    input wire logic       m_tlast
);

    import wbs_pkg::*;

    // a text request occupies the block while the words are scanned
    a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_TEXT) |=> !s_tready)
        else $error("input still ready after a text request");

    // dictionary, clear and unknown-command requests finish in the cycle they are taken
    a_dict_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != CMD_TEXT) |=> s_tready)
        else $error("input not ready after a dictionary request");

    // a new result only comes out of a scan in progress
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a text scan");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind word_break_segmenter wbs_checker u_wbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/word_break_segmenter_tb.sv
// self-checking testbench for the word break segmenter
`timescale 1ns / 1ps

module word_break_segmenter_tb;
    import wbs_pkg::*;

    localparam int WORDS          = MAX_WORDS_DEF;
    localparam int LEN            = MAX_WORD_LEN_DEF;
    localparam int POOL_MAX       = 40;
    localparam int ITEM_TARGET    = 900;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_MAX     = 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic breakable;
        logic text_end;
        logic overflow;
    } split_answer_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // symbol
    logic [1:0] s_tuser;   // cmd
    logic       s_tlast;   // last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // prefix_breakable, then zero fill
    logic [0:0] m_tuser;   // dict_overflow
    logic       m_tlast;   // text_end

    word_break_segmenter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // word break state tracked alongside the block
    logic [7:0]   dict_bytes [WORDS][LEN];
    int           dict_lens [WORDS];
    int           dict_count;
    int           load_pos;
    bit           load_long;
    bit           dropped_flag;
    logic [7:0]   text_recent [LEN];
    logic [LEN:0] split_bits;   // bit k: prefix ending k bytes back splits
    split_answer_t pending_splits [$];

    // words the stimulus builds texts from
    logic [7:0] pool_bytes [POOL_MAX][LEN+1];
    int         pool_len [POOL_MAX];
    int         pool_n;
    logic [7:0] letters [3];

    bit src_gaps;
    bit sink_stalls;
    int stall_left;
    int items_sent;
    int texts_done;
    int words_done;
    int results_seen;
    int mismatch_count;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic clear_dictionary_state();
        int w;
        for (w = 0; w < WORDS; w++)
            dict_lens[w] = 0;
        dict_count   = 0;
        load_pos     = 0;
        load_long    = 1'b0;
        dropped_flag = 1'b0;
    endtask

    task automatic reset_segmentation();
        int w;
        int t;
        for (w = 0; w < WORDS; w++)
            for (t = 0; t < LEN; t++)
                dict_bytes[w][t] = 8'h00;
        for (t = 0; t < LEN; t++)
            text_recent[t] = 8'h00;
        clear_dictionary_state();
        split_bits = {{LEN{1'b0}}, 1'b1};
    endtask

    task automatic update_segmentation(input logic [CMD_W-1:0] cmd, input logic [7:0] sym,
                                       input logic last);
        bit room;
        bit hit;
        bit same;
        int w;
        int t;
        int len;
        split_answer_t ans;
        case (cmd)
            CMD_DICT:
            begin
                room = dict_count < WORDS;
                if (load_pos < LEN)
                begin
                    if (room)
                        dict_bytes[dict_count][load_pos] = sym;
                    load_pos++;
                end
                else
                    load_long = 1'b1;
                if (last)
                begin
                    if (load_long || !room)
                        dropped_flag = 1'b1;
                    else
                    begin
                        dict_lens[dict_count] = load_pos;
                        dict_count++;
                    end
                    load_pos  = 0;
                    load_long = 1'b0;
                end
            end
            CMD_CLEAR:
                clear_dictionary_state();
            CMD_TEXT:
            begin
                for (t = LEN - 1; t > 0; t--)
                    text_recent[t] = text_recent[t-1];
                text_recent[0] = sym;
                split_bits = split_bits << 1;
                hit = 1'b0;
                for (w = 0; w < dict_count; w++)
                begin
                    len = dict_lens[w];
                    if (len >= 1 && len <= LEN && split_bits[len])
                    begin
                        same = 1'b1;
                        // word bytes run oldest first, history newest first
                        for (t = 0; t < len; t++)
                            if (text_recent[len-1-t] != dict_bytes[w][t])
                                same = 1'b0;
                        if (same)
                            hit = 1'b1;
                    end
                end
                split_bits[0] = hit;
                ans.breakable = hit;
                ans.text_end  = last;
                ans.overflow  = dropped_flag;
                pending_splits.push_back(ans);
                if (last)
                    split_bits = {{LEN{1'b0}}, 1'b1};
            end
            default:
                ;
        endcase
    endtask

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [7:0] sym,
                                input logic last);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= sym;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        update_segmentation(cmd, sym, last);
        if (cmd != CMD_UNUSED)
            items_sent++;
        if (cmd == CMD_TEXT && last)
            texts_done++;
        if (cmd == CMD_DICT && last)
            words_done++;
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    task automatic load_pool_word(input int w);
        int b;
        for (b = 0; b < pool_len[w]; b++)
            send_request(CMD_DICT, pool_bytes[w][b], b == pool_len[w] - 1);
    endtask

    task automatic test_directed_words();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_request(CMD_DICT, 8'h00, 1'b1);
        send_request(CMD_DICT, 8'hFF, 1'b0);
        send_request(CMD_DICT, 8'h00, 1'b1);
        send_request(CMD_UNUSED, 8'hA5, 1'b1);
        send_request(CMD_TEXT, 8'h00, 1'b0);
        send_request(CMD_TEXT, 8'hFF, 1'b0);
        send_request(CMD_TEXT, 8'h00, 1'b1);
        // a partly loaded word must not match yet
        send_request(CMD_DICT, 8'h63, 1'b0);
        send_request(CMD_TEXT, 8'h63, 1'b1);
        send_request(CMD_DICT, 8'h64, 1'b1);
        // duplicate word
        send_request(CMD_DICT, 8'h63, 1'b0);
        send_request(CMD_DICT, 8'h64, 1'b1);
        send_request(CMD_TEXT, 8'h63, 1'b0);
        send_request(CMD_TEXT, 8'h64, 1'b0);
        send_request(CMD_TEXT, 8'h00, 1'b0);
        // clear while a text is open
        send_request(CMD_CLEAR, 8'hFF, 1'b1);
        send_request(CMD_TEXT, 8'h00, 1'b1);
        // word added in the middle of a text
        send_request(CMD_TEXT, 8'h5A, 1'b0);
        send_request(CMD_DICT, 8'h5A, 1'b0);
        send_request(CMD_DICT, 8'h5A, 1'b1);
        send_request(CMD_TEXT, 8'h5A, 1'b1);
    endtask

    task automatic test_dropped_words();
        int i;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        // one byte past the longest storable word
        for (i = 0; i <= LEN; i++)
            send_request(CMD_DICT, 8'h77, i == LEN);
        send_request(CMD_TEXT, 8'h77, 1'b1);
        send_request(CMD_CLEAR, 8'h00, 1'b0);
        for (i = 0; i < WORDS; i++)
            send_request(CMD_DICT, 8'(8'h10 + i), 1'b1);
        // dictionary full, this one is dropped
        send_request(CMD_DICT, 8'h40, 1'b1);
        send_request(CMD_TEXT, 8'h40, 1'b0);
        send_request(CMD_TEXT, 8'h1F, 1'b1);
    endtask

    task automatic send_text();
        int parts;
        int p;
        int b;
        int w;
        int r;
        logic fin;
        parts = $urandom_range(1, 5);
        for (p = 0; p < parts; p++)
        begin
            fin = (p == parts - 1);
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                send_request(CMD_CLEAR, 8'($urandom), 1'($urandom));
                pool_n = 0;
            end
            else if (r < 6)
                send_request(CMD_UNUSED, 8'($urandom), 1'($urandom));
            else if (r < 9)
                send_request(CMD_DICT, letters[$urandom_range(0, 2)], 1'($urandom));
            r = $urandom_range(0, 99);
            if (r < 85 && pool_n > 0)
            begin
                w = $urandom_range(0, pool_n - 1);
                for (b = 0; b < pool_len[w]; b++)
                    send_request(CMD_TEXT, pool_bytes[w][b], fin && b == pool_len[w] - 1);
            end
            else if (r < 97)
                send_request(CMD_TEXT, letters[$urandom_range(0, 2)], fin);
            else
                send_request(CMD_TEXT, 8'($urandom), fin);
        end
    endtask

    task automatic test_random_segments();
        int n;
        int i;
        int b;
        int r;
        int texts;
        pool_n = 0;
        while (items_sent < ITEM_TARGET)
        begin
            src_gaps    = $urandom_range(0, 2) != 0;
            sink_stalls = $urandom_range(0, 2) != 0;
            for (i = 0; i < 3; i++)
                letters[i] = 8'($urandom);
            if (pool_n == 0 || pool_n > POOL_MAX - 18 || $urandom_range(0, 9) < 7)
            begin
                send_request(CMD_CLEAR, 8'($urandom), 1'($urandom));
                pool_n = 0;
            end
            n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(10, 18);
            for (i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    pool_len[pool_n] = $urandom_range(1, 3);
                else if (r < 92)
                    pool_len[pool_n] = $urandom_range(4, LEN);
                else if (r < 96)
                    pool_len[pool_n] = LEN;
                else
                    pool_len[pool_n] = LEN + 1;
                for (b = 0; b < pool_len[pool_n]; b++)
                    pool_bytes[pool_n][b] = letters[$urandom_range(0, 2)];
                load_pool_word(pool_n);
                pool_n++;
            end
            texts = $urandom_range(2, 5);
            for (i = 0; i < texts; i++)
                send_text();
        end
    endtask

    // result side: random back-pressure and the compare
    initial
    begin
        split_answer_t want;
        m_tready   <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                if (pending_splits.size() == 0)
                    report_mismatch("result with no request waiting for it");
                else
                begin
                    want = pending_splits.pop_front();
                    if (m_tdata[0] !== want.breakable)
                        report_mismatch($sformatf("prefix_breakable got %b want %b",
                                                  m_tdata[0], want.breakable));
                    if (m_tdata[7:1] !== 7'd0)
                        report_mismatch($sformatf("tdata fill got %h", m_tdata[7:1]));
                    if (m_tlast !== want.text_end)
                        report_mismatch($sformatf("text_end got %b want %b",
                                                  m_tlast, want.text_end));
                    if (m_tuser[0] !== want.overflow)
                        report_mismatch($sformatf("dict_overflow got %b want %b",
                                                  m_tuser[0], want.overflow));
                end
                results_seen++;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // hang detection: no request or result moving for too long
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
                (m_tvalid === 1'b1 && m_tready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d results outstanding", pending_splits.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        items_sent     = 0;
        texts_done     = 0;
        words_done     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        src_gaps       = 1'b0;
        sink_stalls    = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= CMD_DICT;
        s_tlast  <= 1'b0;
        reset_segmentation();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_words();
        test_dropped_words();
        test_random_segments();

        s_tvalid <= 1'b0;
        while (pending_splits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d dictionary words, %0d texts, %0d results checked",
                 items_sent, words_done, texts_done, results_seen);
        $display("summary: covered partial and duplicate words, clears, drops, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/wbs_pkg.sv
rtl/wbs_ram.sv
rtl/wbs_cell.sv
rtl/word_break_segmenter.sv
rtl/wbs_checker.sv
tb/sv/word_break_segmenter_tb.sv
